// ----- design/jsv_pkg.sv -----
// Shared types, character constants and literal tables for the JSON scalar recognizer.
// Depends on nothing; the top level and the grammar state machine use it.
`default_nettype none

package jsv_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EXPECT    = 3'd1,
		ST_INVALID   = 3'd2,
		ST_NOTSINGLE = 3'd3,
		ST_STRING    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		TY_NULL   = 2'd0,
		TY_FALSE  = 2'd1,
		TY_TRUE   = 2'd2,
		TY_NUMBER = 2'd3
	} vtype_t;

	typedef struct packed {
		logic    done_res;
		status_t status;
		vtype_t  value_type;
	} res_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	// Length of a literal; the number kind falls back to the null spelling.
	function automatic logic [2:0] lit_len(input vtype_t kind);
		logic [2:0] len;
		case (kind)
			TY_FALSE: len = 3'd5;
			default:  len = 3'd4;
		endcase
		return len;
	endfunction

	// Expected letter at a given position of a literal.
	function automatic logic [7:0] lit_char(input vtype_t kind, input logic [2:0] pos);
		logic [7:0] ch;
		ch = CH_NUL;
		case (kind)
			TY_FALSE: begin
				case (pos)
					3'd0: ch = CH_F;
					3'd1: ch = CH_A;
					3'd2: ch = CH_L;
					3'd3: ch = CH_S;
					3'd4: ch = CH_E;
					default: ch = CH_NUL;
				endcase
			end
			TY_TRUE: begin
				case (pos)
					3'd0: ch = CH_T;
					3'd1: ch = CH_R;
					3'd2: ch = CH_U;
					3'd3: ch = CH_E;
					default: ch = CH_NUL;
				endcase
			end
			default: begin
				case (pos)
					3'd0: ch = CH_N;
					3'd1: ch = CH_U;
					3'd2: ch = CH_L;
					3'd3: ch = CH_L;
					default: ch = CH_NUL;
				endcase
			end
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ----- design/jsv_in_if.sv -----
// Byte stream channel into the recognizer: valid/ready plus one text byte.
// No dependencies.
`default_nettype none

interface jsv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;

	modport source (output valid, output text_char, input ready);
	modport sink (input valid, input text_char, output ready);
endinterface

`default_nettype wire

// ----- design/jsv_out_if.sv -----
// Result channel out of the recognizer: valid/ready plus decision, status and type.
// No dependencies.
`default_nettype none

interface jsv_out_if;
	logic       valid;
	logic       ready;
	logic       done_res;
	logic [2:0] status;
	logic [1:0] value_type;

	modport source (output valid, output done_res, output status, output value_type,
		input ready);
	modport sink (input valid, input done_res, input status, input value_type,
		output ready);
endinterface

`default_nettype wire

// ----- design/json_scalar_value_recognizer.sv -----
// JSON scalar value recognizer, top level. Depends on jsv_pkg, jsv_in_if,
// jsv_out_if and jsv_parser.
//
// The block takes one byte of JSON text per transaction, a zero byte ending
// each document, and returns exactly one result transaction per byte. It
// accepts a byte in every cycle while results.ready is high. The byte is
// captured in an input register, then the grammar state machine decodes it
// and writes the result register. The only loop is the parse state feeding
// back through one byte decode, so the sustained rate is one byte per clock
// as long as the result side keeps ready high. A result with done_res set
// carries the status of the document (ok with null/false/true/number,
// expect_value, invalid_value, root_not_singular, or string_unsupported for
// a quoted value); bytes after a decision return done_res low until the zero
// byte, which restarts parsing.
`default_nettype none

module json_scalar_value_recognizer (
	input wire logic  clk,
	input wire logic  arst_n,
	jsv_in_if.sink    chars,
	jsv_out_if.source results
);

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          valid_s2;
	logic          advance;
	logic          step;
	jsv_pkg::res_t result_s2;

	// The result register moves when it is empty or being taken.
	assign advance     = !valid_s2 || results.ready;
	assign step        = valid_s1 && advance;
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			char_s1  <= 8'd0;
			valid_s2 <= 1'b0;
		end else begin
			if (chars.ready) begin
				valid_s1 <= chars.valid;
				char_s1  <= chars.text_char;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	jsv_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.text_char (char_s1),
		.result_s2 (result_s2)
	);

	assign results.valid      = valid_s2;
	assign results.done_res   = result_s2.done_res;
	assign results.status     = result_s2.status;
	assign results.value_type = result_s2.value_type;

	// A byte waiting in the input register while the output stalls stays put.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(char_s1))
		else $error("input stage lost or changed a waiting byte");

	// An accepted byte always lands in the input register.
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.ready |=> valid_s1)
		else $error("accepted byte missing from input stage");

	// Without a decision, status and type read as zero.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.done_res |->
		results.status == jsv_pkg::ST_OK && results.value_type == jsv_pkg::TY_NULL)
		else $error("undecided result carries a status");

	// A failed document never reports a value type.
	a_fail_type: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.done_res && results.status != jsv_pkg::ST_OK |->
		results.value_type == jsv_pkg::TY_NULL)
		else $error("value type reported with a failing status");

endmodule

`default_nettype wire

// ----- design/jsv_parser.sv -----
// Grammar state machine: holds the parse phase and the result register, and
// consumes one byte per step. Depends on jsv_pkg.
`default_nettype none

module jsv_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    text_char,
	output jsv_pkg::res_t      result_s2
);

	typedef enum logic [3:0] {
		PH_LEAD    = 4'd0,
		PH_LITERAL = 4'd1,
		PH_SIGN    = 4'd2,
		PH_ZERO    = 4'd3,
		PH_INT     = 4'd4,
		PH_DOT     = 4'd5,
		PH_FRAC    = 4'd6,
		PH_EXP     = 4'd7,
		PH_EXPSIGN = 4'd8,
		PH_EXPDIG  = 4'd9,
		PH_TRAIL   = 4'd10
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [2:0]       lit_pos_q, pos_d, pos_inc;
	jsv_pkg::vtype_t  lit_kind_q, kind_d;
	logic             decided_q, decided_d;
	jsv_pkg::res_t    res_d;

	logic             dec, num_end, is_ex, lit_match;
	jsv_pkg::status_t dec_st;
	jsv_pkg::vtype_t  dec_ty;

	assign is_ex     = (text_char == jsv_pkg::CH_E) || (text_char == jsv_pkg::CH_UP_E);
	assign pos_inc   = lit_pos_q + 3'd1;
	assign lit_match = (lit_pos_q < jsv_pkg::lit_len(lit_kind_q)) &&
		(text_char == jsv_pkg::lit_char(lit_kind_q, lit_pos_q));

	always_comb begin
		phase_d   = phase_q;
		pos_d     = lit_pos_q;
		kind_d    = lit_kind_q;
		decided_d = decided_q;
		res_d     = '0;
		dec       = 1'b0;
		num_end   = 1'b0;
		dec_st    = jsv_pkg::ST_OK;
		dec_ty    = jsv_pkg::TY_NULL;

		if (decided_q) begin
			// Bytes after a decision are dropped; the zero byte restarts.
			if (text_char == jsv_pkg::CH_NUL) begin
				phase_d   = PH_LEAD;
				pos_d     = 3'd0;
				kind_d    = jsv_pkg::TY_NULL;
				decided_d = 1'b0;
			end
		end else begin
			case (phase_q)
				PH_LITERAL: begin
					if (lit_match) begin
						pos_d = pos_inc;
						if (pos_inc >= jsv_pkg::lit_len(lit_kind_q)) begin
							phase_d = PH_TRAIL;
						end
					end else begin
						dec    = 1'b1;
						dec_st = jsv_pkg::ST_INVALID;
					end
				end
				PH_SIGN: begin
					if (text_char == jsv_pkg::CH_0) begin
						phase_d = PH_ZERO;
					end else if (jsv_pkg::is_digit(text_char)) begin
						phase_d = PH_INT;
					end else begin
						dec    = 1'b1;
						dec_st = jsv_pkg::ST_INVALID;
					end
				end
				PH_ZERO: begin
					if (text_char == jsv_pkg::CH_DOT) begin
						phase_d = PH_DOT;
					end else if (is_ex) begin
						phase_d = PH_EXP;
					end else begin
						num_end = 1'b1;
					end
				end
				PH_INT: begin
					if (jsv_pkg::is_digit(text_char)) begin
						phase_d = PH_INT;
					end else if (text_char == jsv_pkg::CH_DOT) begin
						phase_d = PH_DOT;
					end else if (is_ex) begin
						phase_d = PH_EXP;
					end else begin
						num_end = 1'b1;
					end
				end
				PH_DOT: begin
					if (jsv_pkg::is_digit(text_char)) begin
						phase_d = PH_FRAC;
					end else begin
						dec    = 1'b1;
						dec_st = jsv_pkg::ST_INVALID;
					end
				end
				PH_FRAC: begin
					if (jsv_pkg::is_digit(text_char)) begin
						phase_d = PH_FRAC;
					end else if (is_ex) begin
						phase_d = PH_EXP;
					end else begin
						num_end = 1'b1;
					end
				end
				PH_EXP: begin
					if (text_char == jsv_pkg::CH_PLUS || text_char == jsv_pkg::CH_MINUS) begin
						phase_d = PH_EXPSIGN;
					end else if (jsv_pkg::is_digit(text_char)) begin
						phase_d = PH_EXPDIG;
					end else begin
						dec    = 1'b1;
						dec_st = jsv_pkg::ST_INVALID;
					end
				end
				PH_EXPSIGN: begin
					if (jsv_pkg::is_digit(text_char)) begin
						phase_d = PH_EXPDIG;
					end else begin
						dec    = 1'b1;
						dec_st = jsv_pkg::ST_INVALID;
					end
				end
				PH_EXPDIG: begin
					if (jsv_pkg::is_digit(text_char)) begin
						phase_d = PH_EXPDIG;
					end else begin
						num_end = 1'b1;
					end
				end
				PH_TRAIL: begin
					if (text_char == jsv_pkg::CH_NUL) begin
						dec    = 1'b1;
						dec_st = jsv_pkg::ST_OK;
						dec_ty = lit_kind_q;
					end else if (!jsv_pkg::is_space(text_char)) begin
						dec    = 1'b1;
						dec_st = jsv_pkg::ST_NOTSINGLE;
					end
				end
				default: begin
					// Leading whitespace; unused phase codes behave the same way.
					if (jsv_pkg::is_space(text_char)) begin
						phase_d = PH_LEAD;
					end else if (text_char == jsv_pkg::CH_NUL) begin
						dec    = 1'b1;
						dec_st = jsv_pkg::ST_EXPECT;
					end else if (text_char == jsv_pkg::CH_N) begin
						kind_d  = jsv_pkg::TY_NULL;
						pos_d   = 3'd1;
						phase_d = PH_LITERAL;
					end else if (text_char == jsv_pkg::CH_F) begin
						kind_d  = jsv_pkg::TY_FALSE;
						pos_d   = 3'd1;
						phase_d = PH_LITERAL;
					end else if (text_char == jsv_pkg::CH_T) begin
						kind_d  = jsv_pkg::TY_TRUE;
						pos_d   = 3'd1;
						phase_d = PH_LITERAL;
					end else if (text_char == jsv_pkg::CH_QUOTE) begin
						dec    = 1'b1;
						dec_st = jsv_pkg::ST_STRING;
					end else if (text_char == jsv_pkg::CH_MINUS) begin
						kind_d  = jsv_pkg::TY_NUMBER;
						phase_d = PH_SIGN;
					end else if (text_char == jsv_pkg::CH_0) begin
						kind_d  = jsv_pkg::TY_NUMBER;
						phase_d = PH_ZERO;
					end else if (jsv_pkg::is_digit(text_char)) begin
						kind_d  = jsv_pkg::TY_NUMBER;
						phase_d = PH_INT;
					end else begin
						dec    = 1'b1;
						dec_st = jsv_pkg::ST_INVALID;
					end
				end
			endcase

			// A complete number meets a byte that cannot extend it.
			if (num_end) begin
				if (jsv_pkg::is_space(text_char)) begin
					phase_d = PH_TRAIL;
				end else if (text_char == jsv_pkg::CH_NUL) begin
					dec    = 1'b1;
					dec_st = jsv_pkg::ST_OK;
					dec_ty = jsv_pkg::TY_NUMBER;
				end else begin
					dec    = 1'b1;
					dec_st = jsv_pkg::ST_NOTSINGLE;
				end
			end

			if (dec) begin
				res_d.done_res   = 1'b1;
				res_d.status     = dec_st;
				res_d.value_type = (dec_st == jsv_pkg::ST_OK) ? dec_ty : jsv_pkg::TY_NULL;
				phase_d          = PH_LEAD;
				pos_d            = 3'd0;
				kind_d           = jsv_pkg::TY_NULL;
				decided_d        = (text_char != jsv_pkg::CH_NUL);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEAD;
			lit_pos_q  <= 3'd0;
			lit_kind_q <= jsv_pkg::TY_NULL;
			decided_q  <= 1'b0;
			result_s2  <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			lit_pos_q  <= pos_d;
			lit_kind_q <= kind_d;
			decided_q  <= decided_d;
			result_s2  <= res_d;
		end
	end

endmodule

`default_nettype wire
